/* hw/rtl/phone_number_parse_validate_core_assert.svh */
// Assertion macros shared by the phone number parser checker.
`ifndef PHONE_NUMBER_PARSE_VALIDATE_CORE_ASSERT_SVH
`define PHONE_NUMBER_PARSE_VALIDATE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PNP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PNP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pnp_pkg.sv */
// Types, status codes and the calling code table of the phone number parser.
`timescale 1ns / 1ps
package pnp_pkg;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_SHORT   = 3'd2;
	localparam logic [2:0] ST_LONG    = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	// Register map: index taken from paddr[2].
	localparam logic REG_MIN_DIGITS = 1'b0;
	localparam logic [3:0] MIN_DIGITS_RST = 4'd7;
	localparam int PADDR_W = 3;

	// Fixed field widths.
	localparam int STORE_W = 60;
	localparam int TOTAL_W = 5;
	localparam int BCD_W   = 56;

	// Calling code table; row 0 is the no-match row.
	localparam int CODE_ROWS = 54;
	localparam logic [9:0] CODE_TABLE [CODE_ROWS] = '{
		10'd0, 10'd1, 10'd7, 10'd20, 10'd27, 10'd30, 10'd31, 10'd32, 10'd33,
		10'd34, 10'd36, 10'd39, 10'd40, 10'd41, 10'd43, 10'd44, 10'd45, 10'd46,
		10'd47, 10'd48, 10'd49, 10'd51, 10'd52, 10'd54, 10'd55, 10'd56, 10'd57,
		10'd58, 10'd60, 10'd61, 10'd62, 10'd63, 10'd64, 10'd65, 10'd66, 10'd81,
		10'd82, 10'd84, 10'd86, 10'd90, 10'd91, 10'd92, 10'd93, 10'd94, 10'd98,
		10'd212, 10'd213, 10'd216, 10'd234, 10'd254, 10'd255, 10'd966, 10'd971,
		10'd972
	};

	// Digits gathered from one string, handed to the classifier.
	typedef struct packed {
		logic               started;
		logic [TOTAL_W-1:0] total;
		logic [STORE_W-1:0] store;
	} pnp_snap_t;

	// One result item.
	typedef struct packed {
		logic [2:0]       status;
		logic [9:0]       dial_code;
		logic [5:0]       country_index;
		logic [1:0]       code_len;
		logic [3:0]       nat_count;
		logic [BCD_W-1:0] national_bcd;
	} pnp_result_t;

	// Table row whose code equals v, or zero when none does.
	function automatic logic [5:0] code_row(input logic [9:0] v);
		logic [5:0] r;
		r = '0;
		for (int k = 1; k < CODE_ROWS; k++) begin
			if (CODE_TABLE[k] == v) begin
				r = 6'(k);
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pnp_ifs.sv */
// Valid/ready channel interfaces for characters in and results out.
`timescale 1ns / 1ps

// Character channel: one character byte per item.
interface pnp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;
	logic       no_char;

	modport source (output valid, ch, last, no_char, input ready);
	modport sink (input valid, ch, last, no_char, output ready);
endinterface

// Result channel: one parse result per item.
interface pnp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [9:0]  dial_code;
	logic [5:0]  country_index;
	logic [1:0]  code_len;
	logic [3:0]  nat_count;
	logic [55:0] national_bcd;

	modport source (output valid, status, dial_code, country_index, code_len,
		nat_count, national_bcd, input ready);
	modport sink (input valid, status, dial_code, country_index, code_len,
		nat_count, national_bcd, output ready);
endinterface

/* hw/rtl/phone_number_parse_validate_core.sv */
// Top level of the phone number parser and validator.
//
//   Channel   Dir  Handshake        Carries
//   chars     in   valid/ready      ch, last, no_char
//   result    out  valid/ready      status, dial_code, country_index,
//                                   code_len, nat_count, national_bcd
//   APB       in   psel/penable     min_digits at byte address 0
//
// One character item is taken every cycle unless the input register holds an item
// marked last that the snapshot stage cannot take. A result for the item marked last
// passes the input register, snapshot register and result register in turn.
// arst_n empties the pipeline, clears the string state and sets min_digits to 7.
// A waiting result stalls input only once the snapshot stage is full and the
// next item marked last sits in the input register.
`timescale 1ns / 1ps
module phone_number_parse_validate_core #(
	parameter int MAX_DIGITS = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pnp_char_if.sink                    chars,
	pnp_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pnp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import pnp_pkg::*;

	logic [3:0]  min_digits_q;
	logic        snap_valid;
	pnp_snap_t   snap;
	logic        out_free;
	pnp_result_t res;
	pnp_result_t res_q;
	logic        out_v_q;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_DIGITS) ? {28'd0, min_digits_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_digits_q <= MIN_DIGITS_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_DIGITS) begin
			min_digits_q <= pwdata[3:0];
		end
	end

	// Character intake and digit gathering.
	pnp_accum #(.MAX_DIGITS(MAX_DIGITS)) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (out_free)
	);

	// Result computation for a finished string.
	pnp_classify #(.MAX_DIGITS(MAX_DIGITS)) u_classify (
		.snap       (snap),
		.min_digits (min_digits_q),
		.res        (res)
	);

	// Result register.
	assign out_free = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && snap_valid) begin
			res_q <= res;
		end
	end

	assign result.valid         = out_v_q;
	assign result.status        = res_q.status;
	assign result.dial_code     = res_q.dial_code;
	assign result.country_index = res_q.country_index;
	assign result.code_len      = res_q.code_len;
	assign result.nat_count     = res_q.nat_count;
	assign result.national_bcd  = res_q.national_bcd;

endmodule

/* hw/rtl/pnp_accum.sv */
// Input register and per-string digit accumulator of the phone number parser.
`timescale 1ns / 1ps
module pnp_accum #(
	parameter int MAX_DIGITS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	pnp_char_if.sink          chars,
	output logic              snap_valid,
	output pnp_pkg::pnp_snap_t snap,
	input  logic              snap_ready
);
	import pnp_pkg::*;

	localparam logic [TOTAL_W-1:0] TOT_MAX = TOTAL_W'(MAX_DIGITS);

	logic              v_s1;
	logic [7:0]        ch_s1;
	logic              last_s1;
	logic              noch_s1;
	pnp_snap_t         state_q;
	pnp_snap_t         nxt;
	pnp_snap_t         snap_s2;
	logic              v_s2;
	logic              s2_free;
	logic              advance;
	logic              is_space;
	logic              is_digit;

	// Handshake: s1 moves on unless it holds a last item that s2 cannot take.
	assign s2_free     = !v_s2 || snap_ready;
	assign advance     = v_s1 && (!last_s1 || s2_free);
	assign chars.ready = !v_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
			noch_s1 <= chars.no_char;
		end
	end

	// Character classes.
	assign is_space = (ch_s1 == 8'h20) || (ch_s1 >= 8'h09 && ch_s1 <= 8'h0D);
	assign is_digit = (ch_s1 >= 8'h30) && (ch_s1 <= 8'h39);

	// Next string state: mark text start, append a digit, or saturate the count.
	always_comb begin
		nxt = state_q;
		if (!noch_s1) begin
			if (!is_space) begin
				nxt.started = 1'b1;
			end
			if (is_digit) begin
				if (state_q.total < TOT_MAX) begin
					for (int i = 0; i < MAX_DIGITS; i++) begin
						if (state_q.total == TOTAL_W'(i)) begin
							nxt.store[4*i +: 4] = ch_s1[3:0];
						end
					end
					nxt.total = state_q.total + 1'b1;
				end else begin
					nxt.total = TOT_MAX + 1'b1;
				end
			end
		end
	end

	// String state; cleared once the last item has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= last_s1 ? pnp_snap_t'('0) : nxt;
		end
	end

	// Finished string waits here for the classifier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			snap_s2 <= nxt;
		end
	end

	assign snap_valid = v_s2;
	assign snap       = snap_s2;

endmodule

/* hw/rtl/pnp_classify.sv */
// Length checks, calling code match and national number split.
`timescale 1ns / 1ps
module pnp_classify #(
	parameter int MAX_DIGITS = 15
) (
	input  pnp_pkg::pnp_snap_t   snap,
	input  logic [3:0]           min_digits,
	output pnp_pkg::pnp_result_t res
);
	import pnp_pkg::*;

	logic [TOTAL_W-1:0] n;
	logic [3:0]         d0, d1, d2;
	logic [9:0]         v1, v2, v3;
	logic [5:0]         row1, row2, row3;
	logic [TOTAL_W-1:0] rest;
	logic [BCD_W-1:0]   shifted;

	assign n  = snap.total;
	assign d0 = snap.store[3:0];
	assign d1 = snap.store[7:4];
	assign d2 = snap.store[11:8];

	// Candidate codes from the first one, two and three digits.
	assign v1 = 10'(d0);
	assign v2 = 10'(d0) * 10'd10 + 10'(d1);
	assign v3 = 10'(d0) * 10'd100 + 10'(d1) * 10'd10 + 10'(d2);

	assign row1 = (n >= TOTAL_W'(1)) ? code_row(v1) : 6'd0;
	assign row2 = (n >= TOTAL_W'(2)) ? code_row(v2) : 6'd0;
	assign row3 = (n >= TOTAL_W'(3)) ? code_row(v3) : 6'd0;

	// Status and match, longest code first.
	always_comb begin
		res     = '0;
		rest    = '0;
		shifted = '0;
		if (!snap.started) begin
			res.status = ST_EMPTY;
		end else if (n < TOTAL_W'(min_digits)) begin
			res.status = ST_SHORT;
		end else if (n > TOTAL_W'(MAX_DIGITS)) begin
			res.status = ST_LONG;
		end else begin
			res.status = ST_UNKNOWN;
			if (row3 != 6'd0) begin
				res.dial_code     = v3;
				res.country_index = row3;
				res.code_len      = 2'd3;
			end else if (row2 != 6'd0) begin
				res.dial_code     = v2;
				res.country_index = row2;
				res.code_len      = 2'd2;
			end else if (row1 != 6'd0) begin
				res.dial_code     = v1;
				res.country_index = row1;
				res.code_len      = 2'd1;
			end
			// National part after the code.
			case (res.code_len)
				2'd1: shifted = snap.store[4 +: BCD_W];
				2'd2: shifted = BCD_W'(snap.store[STORE_W-1:8]);
				2'd3: shifted = BCD_W'(snap.store[STORE_W-1:12]);
				default: shifted = '0;
			endcase
			rest = n - TOTAL_W'(res.code_len);
			if (res.country_index != 6'd0) begin
				if (rest < TOTAL_W'(4)) begin
					res.status = ST_SHORT;
				end else begin
					res.status       = ST_OK;
					res.nat_count    = rest[3:0];
					res.national_bcd = shifted;
				end
			end
		end
	end

endmodule

/* hw/rtl/pnp_checker.sv */
// Port-level assertions for the phone number parser, bound to the top level.
`timescale 1ns / 1ps
`include "phone_number_parse_validate_core_assert.svh"
module pnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [9:0]  dial_code,
	input logic [5:0]  country_index,
	input logic [1:0]  code_len,
	input logic [3:0]  nat_count,
	input logic [55:0] national_bcd
);
	import pnp_pkg::*;

	logic [80:0] out_bits;
	logic        is_err;
	logic        nat_zero;
	logic        match_ok;

	// Whole result payload, and the conditions that the assertions test.
	assign out_bits = {status, dial_code, country_index, code_len, nat_count, national_bcd};
	assign is_err   = out_valid && status != ST_OK;
	assign nat_zero = nat_count == 4'd0 && national_bcd == '0;
	assign match_ok = ((code_len == 2'd0) == (country_index == 6'd0))
		&& (country_index != 6'd0 || dial_code == 10'd0);

	// A stalled result stays up and unchanged.
	`PNP_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_bits), "stalled result changed")

	// With no result pending the block always takes characters.
	`PNP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with no result pending")

	// Only an accepted number carries national digits.
	`PNP_ASSERT_NOW(a_national_only_ok, is_err, nat_zero, "national fields set on an error result")

	// Code length and table row agree on whether a code matched.
	`PNP_ASSERT_NOW(a_match_fields, out_valid, match_ok, "match fields disagree")

endmodule

bind phone_number_parse_validate_core pnp_checker u_pnp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (chars.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.status        (result.status),
	.dial_code     (result.dial_code),
	.country_index (result.country_index),
	.code_len      (result.code_len),
	.nat_count     (result.nat_count),
	.national_bcd  (result.national_bcd)
);
